// ===== hw/rtl/eitc_pkg.sv =====
// shared types and constants of the ethernet ipv4 tunnel classifier
// no dependencies; the front, queue, back and top files import this package
package eitc_pkg;

    localparam int MAX_FRAME_DEF = 2048;
    localparam int TUNNEL_MAX    = 512;

    localparam int CAP_FIRST = 12;
    localparam int CAP_DEPTH = 30;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [4:0] IP_OFF_PLAIN = 5'd14;
    localparam logic [4:0] IP_OFF_SNAP  = 5'd22;

    localparam logic [7:0] ETH_HI_IP   = 8'h08;
    localparam logic [7:0] ETH_LO_IPV4 = 8'h00;
    localparam logic [7:0] ETH_LO_ARP  = 8'h06;
    localparam logic [7:0] ETH_HI_V6   = 8'h86;
    localparam logic [7:0] ETH_LO_V6   = 8'hDD;
    localparam logic [7:0] SNAP_SAP    = 8'hAA;
    localparam logic [7:0] SNAP_CTRL   = 8'h03;
    localparam logic [7:0] SNAP_OUI    = 8'h00;
    localparam logic [3:0] IHL_MIN     = 4'd5;
    localparam logic [31:0] ADDR_BCAST = 32'hFFFF_FFFF;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PORT_READY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_ADDR = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_FORWARD = 2'd0,
        VERDICT_TUNNEL  = 2'd1,
        VERDICT_DROP    = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        CLS_DROP    = 2'd0,
        CLS_FORWARD = 2'd1,
        CLS_IPV4    = 2'd2
    } cls_t;

    // one classified frame handed from front to back
    typedef struct packed {
        cls_t        cls;
        logic [4:0]  ip_offset;
        logic        ihl_ok;
        logic [9:0]  take;
        logic [31:0] dst;
    } desc_t;

endpackage

// ===== hw/rtl/eitc_in_if.sv =====
// frame byte channel of the classifier
// depends on nothing
interface eitc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

// ===== hw/rtl/eitc_out_if.sv =====
// verdict channel of the classifier
// depends on nothing
interface eitc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [4:0]  ip_offset;
    logic [9:0]  take_length;
    logic [31:0] forwarded_total;
    logic [31:0] tunneled_total;

    modport source (output valid, output verdict, output ip_offset, output take_length,
                    output forwarded_total, output tunneled_total, input ready);
    modport sink   (input valid, input verdict, input ip_offset, input take_length,
                    input forwarded_total, input tunneled_total, output ready);
endinterface

// ===== hw/rtl/eitc_front.sv =====
// front end: byte counter, header capture and per-frame classification
// depends on eitc_pkg and eitc_in_if
module eitc_front #(
    parameter int MAX_FRAME = eitc_pkg::MAX_FRAME_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            port_ready,
    eitc_in_if.sink         frames,
    input  logic            q_full,
    output logic            q_push,
    output eitc_pkg::desc_t q_data
);
    import eitc_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME + 1);

    logic [POS_W-1:0] pos_reg, pos_next, pos_inc, len, iplen;
    logic [7:0]       cap_reg [CAP_DEPTH];
    logic [7:0]       view [CAP_DEPTH];
    logic             accept;
    logic             short_frame, snap, ipv4_plain, known_plain, ipv4, plain;
    logic [3:0]       ihl;
    logic [31:0]      dst;
    logic [4:0]       off;

    assign frames.ready = !q_full;
    assign accept       = frames.valid && frames.ready;
    assign q_push       = accept && frames.last_byte;

    assign pos_inc  = (pos_reg < POS_W'(MAX_FRAME)) ? pos_reg + 1'b1 : pos_reg;
    assign pos_next = frames.last_byte ? '0 : pos_inc;
    assign len      = pos_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAP_DEPTH; i++)
            begin
                cap_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < CAP_DEPTH; i++)
            begin
                if (accept && pos_reg == POS_W'(CAP_FIRST + i))
                begin
                    cap_reg[i] <= frames.frame_byte;
                end
            end
        end
    end

    // capture as it stands once the current byte is in
    always_comb
    begin
        for (int i = 0; i < CAP_DEPTH; i++)
        begin
            view[i] = (pos_reg == POS_W'(CAP_FIRST + i)) ? frames.frame_byte : cap_reg[i];
        end
    end

    assign short_frame = len < POS_W'(14);
    assign ipv4_plain  = view[0] == ETH_HI_IP && view[1] == ETH_LO_IPV4;
    assign known_plain = ipv4_plain
                      || (view[0] == ETH_HI_IP && view[1] == ETH_LO_ARP)
                      || (view[0] == ETH_HI_V6 && view[1] == ETH_LO_V6);
    assign snap = len >= POS_W'(22) && view[0] == SNAP_SAP && view[1] == SNAP_SAP
               && view[2] == SNAP_CTRL && view[3] == SNAP_OUI
               && view[4] == SNAP_OUI && view[5] == SNAP_OUI;

    assign plain = known_plain || !snap;
    assign ipv4  = known_plain ? ipv4_plain
                 : (snap && view[8] == ETH_HI_IP && view[9] == ETH_LO_IPV4);
    assign off   = plain ? IP_OFF_PLAIN : IP_OFF_SNAP;
    assign ihl   = plain ? view[2][3:0] : view[10][3:0];
    assign dst   = plain ? {view[18], view[19], view[20], view[21]}
                         : {view[26], view[27], view[28], view[29]};
    assign iplen = len - POS_W'(off);

    always_comb
    begin
        q_data.ip_offset = off;
        q_data.dst       = dst;
        q_data.ihl_ok    = ihl >= IHL_MIN && iplen >= POS_W'({ihl, 2'b00});
        q_data.take      = (32'(iplen) > 32'(TUNNEL_MAX)) ? 10'(TUNNEL_MAX) : 10'(iplen);
        priority if (!port_ready || short_frame)
        begin
            q_data.cls = CLS_DROP;
        end
        else if (!ipv4)
        begin
            q_data.cls = CLS_FORWARD;
        end
        else
        begin
            q_data.cls = CLS_IPV4;
        end
    end

endmodule

// ===== hw/rtl/eitc_queue.sv =====
// short queue of classified frames between front and back
// depends on eitc_pkg
module eitc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  eitc_pkg::desc_t push_data,
    output logic            full,
    input  logic            pop,
    output eitc_pkg::desc_t pop_data,
    output logic            empty
);
    import eitc_pkg::*;

    desc_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QPTR_W:0]   cnt_reg, cnt_next;

    assign full     = cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH);
    assign empty    = cnt_reg == '0;
    assign pop_data = slot_reg[rd_reg];
    assign cnt_next = cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("queue read while empty");

endmodule

// ===== hw/rtl/eitc_back.sv =====
// back end: address checks, frame counters and the registered verdict
// depends on eitc_pkg and eitc_out_if
module eitc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [31:0]     gateway_addr,
    input  logic            q_empty,
    input  eitc_pkg::desc_t q_data,
    output logic            q_pop,
    eitc_out_if.source      verdicts
);
    import eitc_pkg::*;

    logic        valid_reg;
    verdict_t    verdict_reg, verdict_next;
    logic [4:0]  off_reg, off_next;
    logic [9:0]  take_reg, take_next;
    logic [31:0] fwd_reg, tun_reg;
    logic        local_dst;

    assign q_pop     = !q_empty && (!valid_reg || verdicts.ready);
    assign local_dst = q_data.dst == '0 || q_data.dst == ADDR_BCAST
                    || q_data.dst == gateway_addr;

    always_comb
    begin
        verdict_next = VERDICT_DROP;
        off_next     = '0;
        take_next    = '0;
        unique case (q_data.cls)
            CLS_FORWARD:
            begin
                verdict_next = VERDICT_FORWARD;
            end
            CLS_IPV4:
            begin
                off_next = q_data.ip_offset;
                priority if (!q_data.ihl_ok)
                begin
                    verdict_next = VERDICT_DROP;
                end
                else if (local_dst)
                begin
                    verdict_next = VERDICT_FORWARD;
                end
                else
                begin
                    verdict_next = VERDICT_TUNNEL;
                    take_next    = q_data.take;
                end
            end
            default:
            begin
                verdict_next = VERDICT_DROP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            fwd_reg   <= '0;
            tun_reg   <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                valid_reg <= 1'b1;
                if (verdict_next == VERDICT_FORWARD)
                begin
                    fwd_reg <= fwd_reg + 1'b1;
                end
                if (verdict_next == VERDICT_TUNNEL)
                begin
                    tun_reg <= tun_reg + 1'b1;
                end
            end
            else if (verdicts.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            verdict_reg <= verdict_next;
            off_reg     <= off_next;
            take_reg    <= take_next;
        end
    end

    assign verdicts.valid           = valid_reg;
    assign verdicts.verdict         = verdict_reg;
    assign verdicts.ip_offset       = off_reg;
    assign verdicts.take_length     = take_reg;
    assign verdicts.forwarded_total = fwd_reg;
    assign verdicts.tunneled_total  = tun_reg;

    a_take_only_tunnel: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && verdict_reg != VERDICT_TUNNEL |-> take_reg == '0)
        else $error("take length set on a frame that is not tunneled");
    a_drop_keeps_counts: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && verdict_next == VERDICT_DROP |=> $stable(fwd_reg) && $stable(tun_reg))
        else $error("counter moved on a dropped frame");

endmodule

// ===== hw/rtl/ethernet_ipv4_tunnel_classifier_core.sv =====
// ethernet ipv4 tunnel classifier, top level
// depends on eitc_pkg, eitc_in_if, eitc_out_if, eitc_front, eitc_queue, eitc_back
//
// frames: one frame byte per word, last_byte set on the final word of a frame.
// verdicts: one word per frame: forward, tunnel or drop, the ipv4 header
//   offset, the clamped tunnel length and the running forward/tunnel counts.
// cfg_we/cfg_index/cfg_data write port_ready (index 0) and gateway_addr
//   (index 1); write only while no frame is in flight.
// one byte is taken every cycle while the queue is not full; the front classifies
//   a frame on its last byte and pushes it into a four-entry queue, the back checks
//   addresses, bumps the counters and registers the verdict.
// verdicts.valid rises once the frame's entry has passed the queue and the back has
//   registered its verdict; a stalled verdict receiver can delay it.
// throughput: one frame per cycle unless verdicts stall; single-byte frames run at full rate.
// when the verdict receiver stalls the queue fills; bytes keep flowing until
//   the queue is full, then frames.ready drops.
// reset clears the byte counter, queue, counters and both registers, so
//   frames are dropped until port_ready is written to one.
module ethernet_ipv4_tunnel_classifier_core #(
    parameter int MAX_FRAME = eitc_pkg::MAX_FRAME_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [eitc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_data,
    eitc_in_if.sink                         frames,
    eitc_out_if.source                      verdicts
);
    import eitc_pkg::*;

    logic        port_ready_reg;
    logic [31:0] gateway_reg;
    logic        q_push, q_pop, q_full, q_empty;
    desc_t       q_in, q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_ready_reg <= 1'b0;
            gateway_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PORT_READY:   port_ready_reg <= cfg_data[0];
                REG_GATEWAY_ADDR: gateway_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    eitc_front #(.MAX_FRAME(MAX_FRAME)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .port_ready (port_ready_reg),
        .frames     (frames),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_in)
    );

    eitc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    eitc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .gateway_addr (gateway_reg),
        .q_empty      (q_empty),
        .q_data       (q_out),
        .q_pop        (q_pop),
        .verdicts     (verdicts)
    );

endmodule
